>>> rtl/core/per_flow_token_bucket_policer_defines.svh
// Assertion macros for the policer checker.
`ifndef PER_FLOW_TOKEN_BUCKET_POLICER_DEFINES_SVH
`define PER_FLOW_TOKEN_BUCKET_POLICER_DEFINES_SVH

// Clocked check, muted while reset is held.
`define FTBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FTBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ftbp_pkg.sv
package ftbp_pkg;

  localparam int FLOWS         = 256;
  localparam int TIME_BITS     = 48;
  localparam int CREDIT_BITS   = 48;
  localparam int INTERVAL_BITS = 30;
  localparam int FLOW_ID_BITS  = 8;
  localparam int FLOW_BITS     = $clog2(FLOWS);
  localparam int COUNT_BITS    = $clog2(FLOWS + 1);
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_EVICT   = 2'd1;
  localparam logic [1:0] OP_AGE     = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TOKEN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CREDIT_CEILING = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TIMEOUT   = 2'd2;

  localparam logic [INTERVAL_BITS-1:0] TOKEN_INTERVAL_RST = 30'd1000000;
  localparam logic [CREDIT_BITS-1:0]   CREDIT_CEILING_RST = 48'd16000000;
  localparam logic [TIME_BITS-1:0]     IDLE_TIMEOUT_RST   = 48'd60000000000;

  typedef struct packed {
    logic [1:0]              operation;
    logic [FLOW_ID_BITS-1:0] flow_id;
    logic [TIME_BITS-1:0]    now;
  } item_t;

  typedef struct packed {
    logic                  permitted;
    logic                  removed;
    logic [COUNT_BITS-1:0] live_count;
  } result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   last_seen;
    logic [CREDIT_BITS-1:0] credit;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT
  } state_t;

endpackage

>>> rtl/core/per_flow_token_bucket_policer.sv
// Per-flow token bucket policer.
// Command channel: an item (operation, flow_id, now) is taken at a clock edge
// with start high and busy low. Operations: request, evict flow, age check
// flow, clear all.
// Result channel: done pulses for one cycle with result (permitted, removed,
// live_count). The receiver cannot stall; every result must be taken in its
// cycle.
// Sequence: done and result are registered from the commit state. The bucket
// memory is read at the accepting edge, credit refill is computed in the calc
// state and registered, and the deduction plus write-back to the same entry
// happen in the commit state. busy stays high until the block is back in idle,
// so no new item is taken before the last is written back: the next read sees fresh data.
// Configuration: cfg_we/cfg_index/cfg_data write token_interval (0),
// credit_ceiling (1) and idle_timeout (2); other indexes are
// ignored. Write only while idle.
// Reset (rst, synchronous): registers take their defaults, every flow is
// dead and live_count is zero; busy is high while rst is held. Bucket memory
// is not cleared: an entry's contents are only used while its flow is live.
module per_flow_token_bucket_policer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  ftbp_pkg::item_t                      item,
  output logic                                 done,
  output ftbp_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [ftbp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ftbp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int FB = ftbp_pkg::FLOW_BITS;
  localparam int TB = ftbp_pkg::TIME_BITS;
  localparam int CB = ftbp_pkg::CREDIT_BITS;
  localparam int IB = ftbp_pkg::INTERVAL_BITS;
  localparam int NB = ftbp_pkg::COUNT_BITS;

  ftbp_pkg::state_t state, state_next;
  logic accept;
  logic calc_en;
  logic commit_en;

  logic [IB-1:0] token_interval;
  logic [CB-1:0] credit_ceiling;
  logic [TB-1:0] idle_timeout;

  ftbp_pkg::entry_t mem [ftbp_pkg::FLOWS];
  ftbp_pkg::entry_t rd_data;
  ftbp_pkg::item_t  cur;
  logic [ftbp_pkg::FLOWS-1:0] live;
  logic [NB-1:0] live_total;
  logic [NB-1:0] live_total_next;

  logic [FB-1:0] cur_idx;
  logic          cur_in_range;
  logic          cur_live;

  // refill stage
  logic [TB-1:0] elapsed;
  logic [CB-1:0] headroom;
  logic [CB-1:0] credit_sum;
  logic [TB-1:0] age_cutoff;
  logic [CB-1:0] credit_refill;
  logic          age_hit_next;
  logic [CB-1:0] credit_mid;
  logic          age_hit;

  // commit stage
  logic          grant;
  logic [CB-1:0] credit_final;
  logic          mem_we;
  logic          add_flow;
  logic          drop_flow;
  ftbp_pkg::result_t result_next;

  assign accept       = start && !busy;
  assign cur_idx      = cur.flow_id[FB-1:0];
  assign cur_in_range = {1'b0, cur.flow_id} < (ftbp_pkg::FLOW_ID_BITS + 1)'(ftbp_pkg::FLOWS);
  assign cur_live     = live[cur_idx];

  always_comb begin
    state_next = state;
    case (state)
      ftbp_pkg::S_IDLE:   if (start) state_next = ftbp_pkg::S_CALC;
      ftbp_pkg::S_CALC:   state_next = ftbp_pkg::S_COMMIT;
      ftbp_pkg::S_COMMIT: state_next = ftbp_pkg::S_IDLE;
      default:            state_next = ftbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    calc_en   = 1'b0;
    commit_en = 1'b0;
    case (state)
      ftbp_pkg::S_IDLE:   busy = rst;
      ftbp_pkg::S_CALC:   calc_en = 1'b1;
      ftbp_pkg::S_COMMIT: commit_en = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftbp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_interval <= ftbp_pkg::TOKEN_INTERVAL_RST;
      credit_ceiling <= ftbp_pkg::CREDIT_CEILING_RST;
      idle_timeout   <= ftbp_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ftbp_pkg::REG_TOKEN_INTERVAL: token_interval <= cfg_data[IB-1:0];
        ftbp_pkg::REG_CREDIT_CEILING: credit_ceiling <= cfg_data[CB-1:0];
        ftbp_pkg::REG_IDLE_TIMEOUT:   idle_timeout   <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  // Bucket memory: read on transfer, write back in commit.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_idx] <= '{last_seen: cur.now, credit: credit_final};
    end
    if (accept) begin
      rd_data <= mem[item.flow_id[FB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  // Refill: a dead flow starts full; a live one gains elapsed ticks up to the
  // ceiling (cut back to it if above), only when time moved forward.
  always_comb begin
    elapsed      = cur.now - rd_data.last_seen;
    headroom     = credit_ceiling - rd_data.credit;
    credit_sum   = rd_data.credit + elapsed;
    age_cutoff   = cur.now - idle_timeout;
    if (!cur_live) begin
      credit_refill = credit_ceiling;
    end else if (cur.now > rd_data.last_seen) begin
      if (rd_data.credit >= credit_ceiling || elapsed >= headroom) begin
        credit_refill = credit_ceiling;
      end else begin
        credit_refill = credit_sum;
      end
    end else begin
      credit_refill = rd_data.credit;
    end
    age_hit_next = cur_live && (cur.now > idle_timeout) && (rd_data.last_seen < age_cutoff);
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      credit_mid <= credit_refill;
      age_hit    <= age_hit_next;
    end
  end

  always_comb begin
    grant        = credit_mid >= CB'(token_interval);
    credit_final = grant ? credit_mid - CB'(token_interval) : credit_mid;
    mem_we       = commit_en && cur_in_range && (cur.operation == ftbp_pkg::OP_REQUEST);
    add_flow     = 1'b0;
    drop_flow    = 1'b0;
    result_next  = '0;
    case (cur.operation)
      ftbp_pkg::OP_REQUEST: begin
        add_flow              = cur_in_range && !cur_live;
        result_next.permitted = cur_in_range && grant;
      end
      ftbp_pkg::OP_EVICT: drop_flow = cur_in_range && cur_live;
      ftbp_pkg::OP_AGE:   drop_flow = cur_in_range && age_hit;
      default: ;
    endcase
    result_next.removed = drop_flow;
    if (cur.operation == ftbp_pkg::OP_CLEAR) begin
      live_total_next = '0;
    end else if (add_flow) begin
      live_total_next = live_total + NB'(1);
    end else if (drop_flow && live_total != '0) begin
      live_total_next = live_total - NB'(1);
    end else begin
      live_total_next = live_total;
    end
    result_next.live_count = live_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      live_total <= '0;
      done       <= 1'b0;
    end else begin
      done <= commit_en;
      if (commit_en) begin
        live_total <= live_total_next;
        if (cur.operation == ftbp_pkg::OP_CLEAR) begin
          live <= '0;
        end else if (add_flow) begin
          live[cur_idx] <= 1'b1;
        end else if (drop_flow) begin
          live[cur_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_en) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/core/ftbp_checker.sv
`include "per_flow_token_bucket_policer_defines.svh"

module ftbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ftbp_pkg::result_t result
);

  `FTBP_ASSERT_ALWAYS(a_busy_in_reset, rst |-> busy, "busy low during reset")
  `FTBP_ASSERT(a_done_follows, start && !busy |=> ##2 done, "no result 3 cycles after transfer")
  `FTBP_ASSERT(a_done_has_cause, done |-> $past(start && !busy, 3), "result without a transfer")
  `FTBP_ASSERT(a_flags_exclusive, done |-> !(result.permitted && result.removed), "permitted and removed both set")
  `FTBP_ASSERT(a_count_bound, done |-> (result.live_count <= ftbp_pkg::COUNT_BITS'(ftbp_pkg::FLOWS)), "live count above table size")

endmodule

bind per_flow_token_bucket_policer ftbp_checker u_ftbp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ftbp_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    bit                       is_write;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    item_t                    cmd;
  } script_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t cmd = '0;
  logic done;
  result_t outcome;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  per_flow_token_bucket_policer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (cmd),
    .done      (done),
    .result    (outcome),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // policer shadow: registers and bucket table
  logic [INTERVAL_BITS-1:0] tok_cost;
  logic [CREDIT_BITS-1:0] ceil_credit;
  logic [TIME_BITS-1:0] idle_limit;
  logic [CREDIT_BITS-1:0] flow_credit [FLOWS];
  logic [TIME_BITS-1:0] flow_seen [FLOWS];
  bit flow_live [FLOWS];
  logic [COUNT_BITS-1:0] live_flows;

  script_entry_t script[$];
  result_t verdicts[$];

  int items_planned = 0;
  int issued = 0;
  int gap = 0;
  int took = 0;
  int quiet = 0;
  int stall = 0;
  int accepted = 0;
  int results = 0;
  int writes = 0;
  int permits = 0;
  int removals = 0;
  int mismatches = 0;

  // stimulus generator state
  logic [63:0] gen_time = 64'd0;
  longint unsigned gen_cost = 1000000;
  longint unsigned gen_idle = 60000000000;

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic result_t police(item_t it);
    result_t r;
    logic [TIME_BITS-1:0] gain;
    int f;
    r = '0;
    f = it.flow_id;
    case (it.operation)
      OP_CLEAR: begin
        foreach (flow_live[i]) flow_live[i] = 1'b0;
        live_flows = '0;
      end
      OP_REQUEST: begin
        if (!flow_live[f]) begin
          flow_live[f] = 1'b1;
          live_flows = live_flows + 1'b1;
          flow_credit[f] = ceil_credit;
        end else if (it.now > flow_seen[f]) begin
          gain = it.now - flow_seen[f];
          if (flow_credit[f] >= ceil_credit || gain >= ceil_credit - flow_credit[f]) begin
            flow_credit[f] = ceil_credit;
          end else begin
            flow_credit[f] = flow_credit[f] + gain;
          end
        end
        flow_seen[f] = it.now;
        if (flow_credit[f] >= {{(CREDIT_BITS-INTERVAL_BITS){1'b0}}, tok_cost}) begin
          flow_credit[f] = flow_credit[f] - tok_cost;
          r.permitted = 1'b1;
        end
      end
      OP_EVICT: begin
        if (flow_live[f]) begin
          flow_live[f] = 1'b0;
          live_flows = live_flows - 1'b1;
          r.removed = 1'b1;
        end
      end
      default: begin
        if (flow_live[f] && it.now > idle_limit && flow_seen[f] < it.now - idle_limit) begin
          flow_live[f] = 1'b0;
          live_flows = live_flows - 1'b1;
          r.removed = 1'b1;
        end
      end
    endcase
    r.live_count = live_flows;
    return r;
  endfunction

  task automatic queue_op(logic [1:0] op, logic [7:0] fid, logic [TIME_BITS-1:0] tn);
    script_entry_t s;
    s.is_write = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.cmd.operation = op;
    s.cmd.flow_id = fid;
    s.cmd.now = tn;
    script.push_back(s);
    items_planned++;
  endtask

  task automatic queue_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    script_entry_t s;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.cmd = '0;
    script.push_back(s);
  endtask

  task automatic set_regs(longint unsigned cost, longint unsigned ceil, longint unsigned idle);
    logic [CFG_DATA_BITS-1:0] v;
    v = {18'($urandom), 30'(cost)};  // upper bits are junk, only 30 bits count
    queue_write(REG_TOKEN_INTERVAL, v);
    queue_write(REG_CREDIT_CEILING, 48'(ceil));
    queue_write(REG_IDLE_TIMEOUT, 48'(idle));
    gen_cost = cost;
    gen_idle = idle;
  endtask

  task automatic add_random_items(int n);
    logic [1:0] op;
    logic [7:0] fid;
    logic [7:0] base;
    logic [63:0] tn;
    int unsigned pick;
    int unsigned step_max;
    int unsigned back;
    base = 8'($urandom);
    step_max = (gen_cost / 2 == 0) ? 1 : int'(gen_cost / 2);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) op = OP_REQUEST;
      else if (pick < 82) op = OP_EVICT;
      else if (pick < 98) op = OP_AGE;
      else op = OP_CLEAR;
      // a small set of busy flows keeps buckets live and near the limit
      fid = ($urandom_range(0, 6) == 0) ? 8'($urandom) : base + 8'($urandom_range(0, 5));
      gen_time = gen_time + $urandom_range(0, step_max);
      if (gen_time > TIME_MAX) gen_time = $urandom_range(0, 1000);
      tn = gen_time;
      pick = $urandom_range(0, 99);
      if (op == OP_AGE && pick < 45) begin
        tn = gen_time + gen_idle + $urandom_range(0, 2 * step_max);
      end else if (pick < 4) begin
        tn = {$urandom, $urandom};
      end else if (pick < 5) begin
        tn = TIME_MAX;
      end else if (pick < 6) begin
        tn = 0;
      end else if (pick < 12) begin
        back = $urandom_range(0, step_max);
        tn = (gen_time > back) ? gen_time - back : 0;
      end
      queue_op(op, fid, tn[TIME_BITS-1:0]);
    end
  endtask

  function automatic bit idle_en();
    return (issued + 300 < items_planned) && ((issued / 200) % 4 != 3);
  endfunction

  // driver: at most one command or register write per falling edge; gaps and untaken transfers hold it
  always @(negedge clk) begin : drive
    logic go;
    logic we_next;
    script_entry_t nxt;
    go = 1'b0;
    we_next = 1'b0;
    if (!rst) begin
      if (start && !took) begin
        go = 1'b1;  // transfer not taken yet
      end else begin
        if (start && idle_en() && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
        if (gap != 0) begin
          gap--;
        end else if (script.size() != 0) begin
          nxt = script[0];
          if (!nxt.is_write) begin
            void'(script.pop_front());
            cmd <= nxt.cmd;
            go = 1'b1;
            issued++;
          end else if (verdicts.size() == 0 && quiet >= 4 && !busy) begin
            void'(script.pop_front());
            cfg_index <= nxt.reg_idx;
            cfg_data <= nxt.reg_val;
            we_next = 1'b1;
          end
        end
      end
    end
    start <= go;
    cfg_we <= we_next;
  end

  // monitor: register writes, accepted commands and results
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      took <= 0;
      quiet <= 0;
      stall <= 0;
      tok_cost = TOKEN_INTERVAL_RST;
      ceil_credit = CREDIT_CEILING_RST;
      idle_limit = IDLE_TIMEOUT_RST;
      foreach (flow_live[i]) flow_live[i] = 1'b0;
      live_flows = '0;
    end else begin
      took <= start && !busy;
      if (cfg_we) begin
        writes++;
        case (cfg_index)
          REG_TOKEN_INTERVAL: tok_cost = cfg_data[INTERVAL_BITS-1:0];
          REG_CREDIT_CEILING: ceil_credit = cfg_data[CREDIT_BITS-1:0];
          REG_IDLE_TIMEOUT:   idle_limit = cfg_data[TIME_BITS-1:0];
          default: ;
        endcase
      end
      if (done) begin
        results++;
        if (verdicts.size() == 0) begin
          report_error($sformatf("result %0d with no command outstanding", results));
        end else begin
          want = verdicts.pop_front();
          if (outcome.permitted !== want.permitted)
            report_error($sformatf("result %0d: permitted %b, predicted %b",
                                   results, outcome.permitted, want.permitted));
          if (outcome.removed !== want.removed)
            report_error($sformatf("result %0d: removed %b, predicted %b",
                                   results, outcome.removed, want.removed));
          if (outcome.live_count !== want.live_count)
            report_error($sformatf("result %0d: live_count %0d, predicted %0d",
                                   results, outcome.live_count, want.live_count));
          if (want.permitted) permits++;
          if (want.removed) removals++;
        end
      end
      if (start && !busy) begin
        verdicts.push_back(police(cmd));
        accepted++;
      end
      if (done || (start && !busy)) begin
        quiet <= 0;
        stall <= 0;
      end else begin
        quiet <= quiet + 1;
        stall <= stall + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (stall >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL per_flow_token_bucket_policer");
      $finish;
    end
  end

  initial begin
    // directed part, reset register values
    queue_op(OP_EVICT, 8'd5, 48'd0);               // flow not live
    queue_op(OP_AGE, 8'd5, TIME_MAX);              // flow not live
    queue_op(OP_REQUEST, 8'd0, 48'd0);             // new flow, full credit
    queue_op(OP_REQUEST, 8'd255, TIME_MAX);
    for (int i = 0; i < 13; i++) queue_op(OP_REQUEST, 8'd0, 48'd0);  // time stands still
    queue_op(OP_REQUEST, 8'd0, 48'd500000);        // refill below one token
    queue_op(OP_REQUEST, 8'd0, 48'd100);           // time goes backward
    queue_op(OP_AGE, 8'd0, 48'd1000);              // timeout beyond now
    queue_op(OP_AGE, 8'd255, TIME_MAX);
    queue_op(OP_AGE, 8'd0, 48'd60000000100);       // exactly at cutoff: stays
    queue_op(OP_AGE, 8'd0, 48'd60000000101);       // one past cutoff: removed
    queue_op(OP_EVICT, 8'd255, 48'd7);
    queue_op(OP_REQUEST, 8'd7, 48'd42);
    queue_op(OP_CLEAR, 8'd7, 48'd0);
    queue_op(OP_REQUEST, 8'd7, 48'd42);

    // low extremes
    set_regs(1, 1, 0);
    add_random_items(160);
    // high extremes, plus a write to an index that does not exist
    set_regs(1000000000, TIME_MAX, TIME_MAX);
    queue_write(REG_UNUSED, 48'($urandom));
    add_random_items(160);
    // ceiling under the token cost: a refilled or new bucket cannot grant, and
    // buckets over the new ceiling get cut back on refill
    set_regs(1000, 500, 5000);
    add_random_items(160);
    for (int p = 0; p < 5; p++) begin : rnd_phase
      longint unsigned cost;
      cost = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000000000)
                                         : $urandom_range(1, 5000);
      set_regs(cost, cost * $urandom_range(1, 20) + $urandom_range(0, 3),
               cost * $urandom_range(0, 40));
      add_random_items(160);
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (script.size() != 0 || start) @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d commands over %0d register writes: %0d permitted, %0d flows removed.",
             accepted, writes, permits, removals);
    $display("Checked %0d results, %0d mismatches.", results, mismatches);
    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("PASS per_flow_token_bucket_policer");
    end else begin
      $display("FAIL per_flow_token_bucket_policer");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ftbp_pkg.sv
rtl/core/per_flow_token_bucket_policer.sv
rtl/core/ftbp_checker.sv
verif/tb.sv
